>>> sv/ekr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekr_pkg
// Shared widths, action codes and command type of the exact-length walk
// reachability block.
// ----------------------------------------------------------------------------
package ekr_pkg;

	localparam int VERTICES_DEF = 16;
	localparam int MAX_WALK_DEF = 1023;

	localparam int ACTION_W   = 2;
	localparam int VIDX_W     = 4;
	localparam int LEN_W      = 10;
	localparam int VCOUNT_W   = 5;
	localparam int VCMP_W     = 7;
	localparam int WALK_CMP_W = 17;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(16);

	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic              clear;
		logic              add;
		logic [VIDX_W-1:0] row;
		logic [VIDX_W-1:0] col;
	} adj_cmd_t;

endpackage

>>> sv/ekr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekr_ifs
// Valid/ready channels for request items, result items and the vertex count
// register write.
// ----------------------------------------------------------------------------
interface ekr_req_if;
	import ekr_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [VIDX_W-1:0]   src_vertex;
	logic [VIDX_W-1:0]   dst_vertex;
	logic [LEN_W-1:0]    walk_length;

	modport source (output valid, action, src_vertex, dst_vertex, walk_length, input ready);
	modport sink (input valid, action, src_vertex, dst_vertex, walk_length, output ready);
endinterface

interface ekr_rsp_if;
	logic valid;
	logic ready;
	logic reachable;
	logic rejected;

	modport source (output valid, reachable, rejected, input ready);
	modport sink (input valid, reachable, rejected, output ready);
endinterface

interface ekr_cfg_if;
	import ekr_pkg::*;
	logic                valid;
	logic                ready;
	logic [VCOUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> sv/ekr_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekr_step_unit
// Adjacency matrix storage and the shared vector-matrix step: the next
// vector is the OR of the rows of all vertices set in the current vector, masked to the active vertices.
// ----------------------------------------------------------------------------
module ekr_step_unit
	import ekr_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  adj_cmd_t            cmd,
	input  logic [VERTICES-1:0] vec,
	input  logic [VERTICES-1:0] act,
	output logic [VERTICES-1:0] vec_next
);

	logic [VERTICES-1:0] adj_q [VERTICES];
	logic [VERTICES-1:0] col_onehot;
	logic [VERTICES-1:0] acc;

	always_comb begin
		for (int i = 0; i < VERTICES; i++) begin
			col_onehot[i] = (VCMP_W'(i) == VCMP_W'(cmd.col));
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < VERTICES; i++) begin
			if (vec[i]) begin
				acc = acc | adj_q[i];
			end
		end
		vec_next = acc & act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < VERTICES; r++) begin
				adj_q[r] <= '0;
			end
		end else if (cmd.clear) begin
			for (int r = 0; r < VERTICES; r++) begin
				adj_q[r] <= '0;
			end
		end else if (cmd.add) begin
			for (int r = 0; r < VERTICES; r++) begin
				if (VCMP_W'(r) == VCMP_W'(cmd.row)) begin
					adj_q[r] <= adj_q[r] | col_onehot;
				end
			end
		end
	end

endmodule

>>> sv/ekr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekr_ctrl
// Request decode, vertex count register, walk sequencer and result register.
// ----------------------------------------------------------------------------
module ekr_ctrl
	import ekr_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF,
	parameter int MAX_WALK = MAX_WALK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	ekr_req_if.sink             req,
	ekr_rsp_if.source           rsp,
	ekr_cfg_if.sink             cfg,
	output adj_cmd_t            cmd,
	output logic [VERTICES-1:0] vec,
	output logic [VERTICES-1:0] act,
	input  logic [VERTICES-1:0] vec_next
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [VCOUNT_W-1:0] vcount_q;
	logic [VERTICES-1:0] vec_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [VIDX_W-1:0]   dst_q;
	logic                rej_q;
	logic                out_valid_q;
	logic                reachable_q;
	logic                rejected_q;

	logic [VCMP_W-1:0]   n_eff;
	logic                fire;
	logic                emit_go;
	logic                src_ok;
	logic                dst_ok;
	logic                len_ok;
	logic [VERTICES-1:0] src_onehot;
	logic [VERTICES-1:0] dst_onehot;

	assign n_eff = (VCMP_W'(vcount_q) > VCMP_W'(VERTICES)) ? VCMP_W'(VERTICES)
		: VCMP_W'(vcount_q);

	always_comb begin
		for (int i = 0; i < VERTICES; i++) begin
			act[i]        = (VCMP_W'(i) < n_eff);
			src_onehot[i] = (VCMP_W'(i) == VCMP_W'(req.src_vertex));
			dst_onehot[i] = (VCMP_W'(i) == VCMP_W'(dst_q));
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign fire      = req.valid && req.ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);
	assign src_ok    = VCMP_W'(req.src_vertex) < n_eff;
	assign dst_ok    = VCMP_W'(req.dst_vertex) < n_eff;
	assign len_ok    = (req.walk_length != '0)
		&& (WALK_CMP_W'(req.walk_length) <= WALK_CMP_W'(MAX_WALK));

	assign cmd.clear = fire && (req.action == ACT_CLEAR);
	assign cmd.add   = fire && (req.action == ACT_ADD) && src_ok && dst_ok;
	assign cmd.row   = req.src_vertex;
	assign cmd.col   = req.dst_vertex;

	assign vec = vec_q;

	assign cfg.ready     = 1'b1;
	assign rsp.valid     = out_valid_q;
	assign rsp.reachable = reachable_q;
	assign rsp.rejected  = rejected_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= VCOUNT_RESET;
			vec_q       <= '0;
			cnt_q       <= '0;
			dst_q       <= '0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
			reachable_q <= 1'b0;
			rejected_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				vcount_q <= cfg.data;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (fire && (req.action == ACT_QUERY)) begin
						dst_q <= req.dst_vertex;
						if (src_ok && dst_ok && len_ok) begin
							rej_q   <= 1'b0;
							vec_q   <= src_onehot;
							cnt_q   <= req.walk_length;
							state_q <= ST_RUN;
						end else begin
							rej_q   <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RUN: begin
					vec_q <= vec_next;
					cnt_q <= cnt_q - LEN_W'(1);
					if (cnt_q == LEN_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						reachable_q <= !rej_q && |(vec_q & dst_onehot);
						rejected_q  <= rej_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_run_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q != '0)
		else $error("walk sequencer running with no moves left");

	a_query_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.action == ACT_QUERY) |=> state_q != ST_IDLE)
		else $error("accepted query did not start");

	a_rejected_not_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rejected_q |-> !reachable_q)
		else $error("rejected result marked reachable");

	a_vector_active_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (vec_q & ~act) == '0)
		else $error("walk vector holds an inactive vertex");

endmodule

>>> sv/exact_k_step_reachability_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_k_step_reachability_top
// Exact-length walk reachability over a boolean adjacency matrix.
// ----------------------------------------------------------------------------
// Clear and add-edge beats are taken in the idle state and leave it idle. A
// query beat runs walk_length moves in the step loop, where one shared
// vector-matrix step unit advances the reach vector by one move per cycle,
// then posts its result from the emit state and returns to idle; the emit
// state waits while an earlier result still sits in the output register.
// A refused query skips the step loop and goes straight to the emit state.
// The request channel is not ready while a query walks; a posted result
// waits in the output register while clear and add beats keep being taken.
// ----------------------------------------------------------------------------
module exact_k_step_reachability_top
	import ekr_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF,
	parameter int MAX_WALK = MAX_WALK_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ekr_req_if.sink   req,
	ekr_rsp_if.source rsp,
	ekr_cfg_if.sink   cfg
);

	adj_cmd_t            cmd;
	logic [VERTICES-1:0] vec;
	logic [VERTICES-1:0] act;
	logic [VERTICES-1:0] vec_next;

	ekr_ctrl #(
		.VERTICES (VERTICES),
		.MAX_WALK (MAX_WALK)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.cmd      (cmd),
		.vec      (vec),
		.act      (act),
		.vec_next (vec_next)
	);

	ekr_step_unit #(
		.VERTICES (VERTICES)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.vec      (vec),
		.act      (act),
		.vec_next (vec_next)
	);

endmodule

>>> verif/exact_k_step_reachability_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_k_step_reachability_top_tb
// Self-checking bench for the exact-length walk reachability block. Beats go
// in on the request channel; accepted clear and edge beats update a local copy
// of the adjacency matrix, vertex count writes a local vertex count, and each
// accepted query beat queues its predicted answer. Each accepted answer is
// checked against the oldest queued one. Directed graphs cover empty, ring,
// self-loop and stale-edge cases and the vertex count extremes. Random traffic
// phases then run with no idling, sender gaps, receiver stalls and both together.
// ----------------------------------------------------------------------------
module exact_k_step_reachability_top_tb;
	import ekr_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam realtime HALF_PERIOD = 2.0;

	typedef struct packed {
		logic reachable;
		logic rejected;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	ekr_req_if req_ch();
	ekr_rsp_if rsp_ch();
	ekr_cfg_if cfg_ch();

	exact_k_step_reachability_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	logic [VERTICES_DEF-1:0] edge_rows [VERTICES_DEF];
	logic [VCOUNT_W-1:0]     vertex_limit;
	answer_t                 pending_answers [$];
	int                      error_count;
	int                      send_gap_pct;
	int                      accept_stall_pct;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int live_count();
		return (vertex_limit > VERTICES_DEF) ? VERTICES_DEF : int'(vertex_limit);
	endfunction

	function automatic answer_t predict_walk(logic [VIDX_W-1:0] src, logic [VIDX_W-1:0] dst,
			logic [LEN_W-1:0] steps);
		int                      n;
		logic [VERTICES_DEF-1:0] live;
		logic [VERTICES_DEF-1:0] reach;
		logic [VERTICES_DEF-1:0] next_reach;
		answer_t                 ans;
		n = live_count();
		live = (n >= VERTICES_DEF) ? '1 : VERTICES_DEF'((1 << n) - 1);
		ans.reachable = 1'b0;
		ans.rejected = 1'b1;
		if (src >= n || dst >= n || steps == 0)
			return ans;
		reach = edge_rows[src] & live;
		for (int k = 1; k < steps; k++) begin
			next_reach = '0;
			for (int v = 0; v < VERTICES_DEF; v++)
				if (reach[v])
					next_reach |= edge_rows[v];
			reach = next_reach & live;
		end
		ans.reachable = reach[dst];
		ans.rejected = 1'b0;
		return ans;
	endfunction

	always @(posedge clk) begin : monitor
		answer_t got;
		answer_t want;
		if (cfg_ch.valid && cfg_ch.ready)
			vertex_limit = cfg_ch.data;
		if (req_ch.valid && req_ch.ready) begin
			case (req_ch.action)
				ACT_CLEAR: begin
					for (int v = 0; v < VERTICES_DEF; v++)
						edge_rows[v] = '0;
				end
				ACT_ADD: begin
					if (req_ch.src_vertex < live_count() && req_ch.dst_vertex < live_count())
						edge_rows[req_ch.src_vertex][req_ch.dst_vertex] = 1'b1;
				end
				ACT_QUERY: begin
					pending_answers.push_back(predict_walk(req_ch.src_vertex,
						req_ch.dst_vertex, req_ch.walk_length));
				end
				default: begin
				end
			endcase
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.reachable = rsp_ch.reachable;
			got.rejected = rsp_ch.rejected;
			if (pending_answers.size() == 0) begin
				$display("%0t: answer reachable=%0b rejected=%0b with none expected",
					$time, got.reachable, got.rejected);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (got.reachable !== want.reachable || got.rejected !== want.rejected) begin
					$display("%0t: expected reachable=%0b rejected=%0b, got reachable=%0b rejected=%0b",
						$time, want.reachable, want.rejected, got.reachable, got.rejected);
					error_count++;
				end
			end
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= accept_stall_pct);

	task automatic send_beat(logic [ACTION_W-1:0] act, logic [VIDX_W-1:0] src,
			logic [VIDX_W-1:0] dst, logic [LEN_W-1:0] steps);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.src_vertex <= src;
		req_ch.dst_vertex <= dst;
		req_ch.walk_length <= steps;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// hold off until every queued answer is back, then let edge beats land
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_empty_graph();
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd1);
		send_beat(ACT_QUERY, 4'd15, 4'd15, 10'd1023);
		send_beat(ACT_QUERY, 4'd3, 4'd4, 10'd0);
		send_beat(ACT_UNUSED, 4'd15, 4'd15, 10'd1023);
	endtask

	task automatic test_ring_walks();
		send_beat(ACT_ADD, 4'd0, 4'd1, 10'd0);
		send_beat(ACT_ADD, 4'd1, 4'd15, 10'd0);
		send_beat(ACT_ADD, 4'd15, 4'd0, 10'd0);
		send_beat(ACT_QUERY, 4'd0, 4'd15, 10'd2);
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd3);
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd1023);
		send_beat(ACT_QUERY, 4'd15, 4'd1, 10'd2);
		send_beat(ACT_QUERY, 4'd1, 4'd0, 10'd1);
	endtask

	task automatic test_vertex_limits();
		// ring edges through vertex 15 go stale
		write_vertex_count(5'd2);
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd3);
		write_vertex_count(5'd1);
		send_beat(ACT_ADD, 4'd0, 4'd0, 10'd0);
		send_beat(ACT_ADD, 4'd0, 4'd1, 10'd0);
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd1023);
		send_beat(ACT_QUERY, 4'd0, 4'd1, 10'd1);
		write_vertex_count(5'd0);
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd1);
		send_beat(ACT_ADD, 4'd0, 4'd0, 10'd0);
		write_vertex_count(5'd31);
		send_beat(ACT_QUERY, 4'd15, 4'd0, 10'd1);
		send_beat(ACT_CLEAR, 4'd0, 4'd0, 10'd0);
		send_beat(ACT_QUERY, 4'd0, 4'd0, 10'd1);
	endtask

	task automatic test_random_traffic(logic [VCOUNT_W-1:0] limit, int gap_pct, int stall_pct,
			int beats);
		int                  n;
		int                  pick;
		logic [ACTION_W-1:0] act;
		logic [VIDX_W-1:0]   src;
		logic [VIDX_W-1:0]   dst;
		logic [LEN_W-1:0]    steps;
		write_vertex_count(limit);
		send_gap_pct = gap_pct;
		accept_stall_pct = stall_pct;
		n = live_count();
		for (int i = 0; i < beats; i++) begin
			if (i == beats / 2)
				settle();
			src = ($urandom_range(9) == 0) ? VIDX_W'($urandom) : VIDX_W'($urandom_range(n - 1));
			dst = ($urandom_range(9) == 0) ? VIDX_W'($urandom) : VIDX_W'($urandom_range(n - 1));
			pick = $urandom_range(99);
			if (pick < 80)
				steps = LEN_W'($urandom_range(20, 1));
			else if (pick < 92)
				steps = LEN_W'($urandom_range(64, 21));
			else if (pick < 97)
				steps = LEN_W'($urandom);
			else
				steps = '0;
			pick = $urandom_range(99);
			if (pick < 3)
				act = ACT_CLEAR;
			else if (pick < 45)
				act = ACT_ADD;
			else if (pick < 97)
				act = ACT_QUERY;
			else
				act = ACT_UNUSED;
			send_beat(act, src, dst, steps);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_CLEAR;
		req_ch.src_vertex = '0;
		req_ch.dst_vertex = '0;
		req_ch.walk_length = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		error_count = 0;
		send_gap_pct = 0;
		accept_stall_pct = 0;
		vertex_limit = VCOUNT_RESET;
		for (int v = 0; v < VERTICES_DEF; v++)
			edge_rows[v] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_graph();
		test_ring_walks();
		test_vertex_limits();
		test_random_traffic(5'd16, 0, 0, 290);
		test_random_traffic(5'd7, 57, 0, 280);
		test_random_traffic(5'd31, 0, 57, 280);
		test_random_traffic(5'd12, 18, 18, 280);

		settle();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> exact_k_step_reachability_top.f
sv/ekr_pkg.sv
sv/ekr_ifs.sv
sv/ekr_step_unit.sv
sv/ekr_ctrl.sv
sv/exact_k_step_reachability_top.sv
verif/exact_k_step_reachability_top_tb.sv
